>>> sv/esr_pkg.sv
// ----------------------------------------------------------------------------
// esr_pkg
// Shared types and constants of the ellipse alpha splat rasterizer.
// ----------------------------------------------------------------------------
package esr_pkg;

  localparam int unsigned QuotBits = 8;

  localparam logic [1:0] OP_DRAW  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [7:0] ALPHA_CAP_RESET = 8'd32;
  localparam logic [7:0] ALPHA_FULL      = 8'd255;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_RDOUT,
    S_SQ,
    S_DEN,
    S_ROW,
    S_SRCH,
    S_PT,
    S_DIV,
    S_RD,
    S_WB,
    S_FIN
  } state_e;

endpackage

>>> sv/esr_div.sv
// ----------------------------------------------------------------------------
// esr_div
// Restoring divider, one quotient bit per cycle; the quotient fits 8 bits.
// ----------------------------------------------------------------------------
module esr_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [23:0] den_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [7:0]  quot_o
);
  import esr_pkg::*;

  logic [31:0] rem_q, rem_d;
  logic [31:0] dsh_q, dsh_d;
  logic [7:0]  quot_q, quot_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic        take;

  assign take = rem_q >= dsh_q;

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_i;
      dsh_d  = {1'b0, den_i, 7'd0};
      quot_d = '0;
      cnt_d  = 3'(QuotBits - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (take) begin
        rem_d = rem_q - dsh_q;
      end
      quot_d = {quot_q[6:0], take};
      dsh_d  = dsh_q >> 1;
      cnt_d  = cnt_q - 3'd1;
      if (cnt_q == 3'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
    cnt_q  <= cnt_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> sv/esr_mem.sv
// ----------------------------------------------------------------------------
// esr_mem
// Alpha tile storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module esr_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);
  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/ellipse_alpha_splat_rasterizer.sv
// ----------------------------------------------------------------------------
// ellipse_alpha_splat_rasterizer
// Alpha tile with ellipse splatting, pixel read and tile clear.
// ----------------------------------------------------------------------------
// Usage: input items arrive on in_valid_i/in_ready_o, one result item per input
// item leaves on out_valid_o/out_ready_i. alpha_cap is written with cfg_we_i.
// One item is worked on at a time; in_ready_o is high in the idle state.
// The result sits in an output register, so the next item is taken while
// the previous result still waits; a finished item then waits for the slot.
// A read passes from the idle state through S_RDOUT to S_FIN; an unused
// operation or a rejected draw goes straight to S_FIN. A clear sweeps the
// tile one entry a cycle. A draw spends S_SQ and S_DEN on setup, then visits
// each covered offset (dx,dy) of one quadrant: S_PT and the 8-step divider
// for the distance term, one S_RD read per mirror, one more S_WB write-back
// per mirrored pixel that exists, plus S_ROW and a final S_SRCH per row and
// one S_SRCH per step of the row-limit search. The tile read-modify-write
// and the divider take most of a draw's time.
// After reset the same sweep clears the tile before the first item is
// taken; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module ellipse_alpha_splat_rasterizer #(
  parameter int unsigned TILE_WIDTH  = 64,
  parameter int unsigned TILE_HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [5:0]  center_x_i,
  input  logic [5:0]  center_y_i,
  input  logic [5:0]  half_axis_x_i,
  input  logic [5:0]  half_axis_y_i,
  input  logic [11:0] pixel_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  pixel_alpha_o,
  output logic [0:0]  status_o
);
  import esr_pkg::*;

  localparam int unsigned Depth = TILE_WIDTH * TILE_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);

  state_e state_q, state_d;
  logic [7:0]  cap_q;
  logic [5:0]  cx_q, cx_d, cy_q, cy_d, w_q, w_d, h_q, h_d;
  logic [11:0] w2_q, w2_d, h2_q, h2_d;
  logic [23:0] den_q, den_d, yterm_q, yterm_d;
  logic [5:0]  dx_q, dx_d, dy_q, dy_d;
  logic [11:0] dx2_q, dx2_d, dy2_q, dy2_d;
  logic [6:0]  lw_q, lw_d, ld_q, ld_d, lim_q, lim_d;
  logic [12:0] ll_q, ll_d;
  logic [1:0]  quad_q, quad_d;
  logic [7:0]  cov_q, cov_d;
  logic        rd_ok_q, rd_ok_d, clr_op_q, clr_op_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [7:0]  res_alpha_q, res_alpha_d;
  logic        res_status_q, res_status_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  pix_out_q, pix_out_d;
  logic        stat_out_q, stat_out_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;
  logic          div_start, div_busy, div_done;
  logic [7:0]    div_quot;
  logic [31:0]   div_num;

  logic [6:0]  px, py;
  logic [16:0] pix_addr_w, idx_w;
  logic        quad_ok, reject, accept;
  logic [24:0] t_sum;
  logic [23:0] t_val;
  logic [25:0] srch_sum;
  logic [8:0]  row_start;
  logic [6:0]  row_lim;
  logic [15:0] blend_prod;
  logic [8:0]  blend_sum;
  logic [7:0]  blend_val;
  logic        last_quad;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign in_ready_o = (state_q == S_IDLE);

  assign reject = (half_axis_x_i == 6'd0) || (half_axis_y_i == 6'd0) ||
                  (center_x_i < half_axis_x_i) || (center_y_i < half_axis_y_i) ||
                  (9'({1'b0, center_x_i} + {1'b0, half_axis_x_i}) >= 9'(TILE_WIDTH)) ||
                  (9'({1'b0, center_y_i} + {1'b0, half_axis_y_i}) >= 9'(TILE_HEIGHT));

  // Quadrant bit 0 mirrors in x, bit 1 in y; a zero offset has no mirror.
  assign quad_ok   = !(quad_q[0] && dx_q == 6'd0) && !(quad_q[1] && dy_q == 6'd0);
  assign px        = quad_q[0] ? 7'(cx_q) - 7'(dx_q) : 7'(cx_q) + 7'(dx_q);
  assign py        = quad_q[1] ? 7'(cy_q) - 7'(dy_q) : 7'(cy_q) + 7'(dy_q);
  assign pix_addr_w = 17'(py) * 17'(TILE_WIDTH) + 17'(px);
  assign idx_w     = 17'(pixel_index_i);
  assign last_quad = (quad_q == 2'd3);

  // Covered offsets never lie beyond the ellipse, so t never exceeds the denominator.
  assign t_sum   = 25'(dx2_q * h2_q) + 25'(yterm_q);
  assign t_val   = t_sum[23:0];
  assign div_num = {t_val, 8'd0} - 32'(t_val);

  assign srch_sum  = 26'(ll_q * h2_q) + 26'(yterm_q);
  assign row_start = 9'(lw_q) - 9'(ld_q) + 9'd1;
  assign row_lim   = row_start[8] ? 7'd0 : row_start[6:0];

  assign blend_prod = cov_q * (ALPHA_FULL - mem_rdata);
  assign blend_sum  = 9'(mem_rdata) + 9'(blend_prod[15:8]);
  assign blend_val  = (blend_sum > 9'(cap_q)) ? cap_q : blend_sum[7:0];

  always_comb begin
    state_d      = state_q;
    cx_d = cx_q; cy_d = cy_q; w_d = w_q; h_d = h_q;
    w2_d = w2_q; h2_d = h2_q; den_d = den_q; yterm_d = yterm_q;
    dx_d = dx_q; dy_d = dy_q; dx2_d = dx2_q; dy2_d = dy2_q;
    lw_d = lw_q; ld_d = ld_q; lim_d = lim_q; ll_d = ll_q;
    quad_d = quad_q; cov_d = cov_q; rd_ok_d = rd_ok_q; clr_op_d = clr_op_q;
    clr_cnt_d    = clr_cnt_q;
    res_alpha_d  = res_alpha_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    pix_out_d    = pix_out_q;
    stat_out_d   = stat_out_q;
    mem_we       = 1'b0;
    mem_waddr    = pix_addr_w[AW-1:0];
    mem_wdata    = blend_val;
    mem_raddr    = pix_addr_w[AW-1:0];
    div_start    = 1'b0;

    unique case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(Depth - 1)) begin
          state_d = clr_op_q ? S_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        mem_raddr = idx_w[AW-1:0];
        if (accept) begin
          cx_d = center_x_i; cy_d = center_y_i;
          w_d  = half_axis_x_i; h_d = half_axis_y_i;
          res_alpha_d  = '0;
          res_status_d = 1'b0;
          rd_ok_d      = idx_w < 17'(Depth);
          priority case (operation_i)
            OP_DRAW: begin
              if (reject) begin
                res_status_d = 1'b1;
                state_d      = S_FIN;
              end else begin
                state_d = S_SQ;
              end
            end
            OP_READ:  state_d = S_RDOUT;
            OP_CLEAR: begin
              clr_cnt_d = '0;
              clr_op_d  = 1'b1;
              state_d   = S_CLR;
            end
            default:  state_d = S_FIN;
          endcase
        end
      end
      S_RDOUT: begin
        res_alpha_d = rd_ok_q ? mem_rdata : 8'd0;
        state_d     = S_FIN;
      end
      S_SQ: begin
        w2_d    = 12'(w_q * w_q);
        h2_d    = 12'(h_q * h_q);
        state_d = S_DEN;
      end
      S_DEN: begin
        den_d   = 24'(w2_q * h2_q);
        dy_d    = '0; dy2_d = '0; yterm_d = '0;
        dx_d    = '0; dx2_d = '0;
        lim_d   = 7'(w_q); lw_d = 7'(w_q); ld_d = '0;
        state_d = S_PT;
      end
      S_ROW: begin
        yterm_d = 24'(dy2_q * w2_q);
        lim_d   = row_lim;
        ll_d    = 13'(row_lim * row_lim);
        state_d = S_SRCH;
      end
      S_SRCH: begin
        if (lim_q != 7'd0 && srch_sum > 26'(den_q)) begin
          lim_d = lim_q - 7'd1;
          ll_d  = ll_q - {5'd0, lim_q, 1'b0} + 13'd1;
        end else begin
          ld_d    = lw_q - lim_q;
          lw_d    = lim_q;
          dx_d    = '0;
          dx2_d   = '0;
          state_d = S_PT;
        end
      end
      S_PT: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          cov_d   = ALPHA_FULL - div_quot;
          quad_d  = '0;
          state_d = S_RD;
        end
      end
      S_RD, S_WB: begin
        if (state_q == S_WB) begin
          mem_we = 1'b1;
        end
        if (state_q == S_RD && quad_ok) begin
          state_d = S_WB;
        end else if (!last_quad) begin
          quad_d  = quad_q + 2'd1;
          state_d = S_RD;
        end else if (7'(dx_q) < lim_q) begin
          dx_d    = dx_q + 6'd1;
          dx2_d   = dx2_q + {5'd0, dx_q, 1'b0} + 12'd1;
          state_d = S_PT;
        end else if (dy_q < h_q) begin
          dy_d    = dy_q + 6'd1;
          dy2_d   = dy2_q + {5'd0, dy_q, 1'b0} + 12'd1;
          state_d = S_ROW;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          pix_out_d   = res_alpha_q;
          stat_out_d  = res_status_q;
          clr_op_d    = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_cnt_q   <= '0;
      clr_op_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cap_q       <= ALPHA_CAP_RESET;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_op_q    <= clr_op_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q <= cx_d; cy_q <= cy_d; w_q <= w_d; h_q <= h_d;
    w2_q <= w2_d; h2_q <= h2_d; den_q <= den_d; yterm_q <= yterm_d;
    dx_q <= dx_d; dy_q <= dy_d; dx2_q <= dx2_d; dy2_q <= dy2_d;
    lw_q <= lw_d; ld_q <= ld_d; lim_q <= lim_d; ll_q <= ll_d;
    quad_q <= quad_d; cov_q <= cov_d; rd_ok_q <= rd_ok_d;
    res_alpha_q  <= res_alpha_d;
    res_status_q <= res_status_d;
    pix_out_q    <= pix_out_d;
    stat_out_q   <= stat_out_d;
  end

  esr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  esr_mem #(
    .DEPTH (Depth),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign pixel_alpha_o = pix_out_q;
  assign status_o      = stat_out_q;

  a_ready_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_busy) else $error("divider busy while taking an item");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_WB || state_q == S_CLR))
    else $error("tile written outside a write state");

  a_blend_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WB |-> mem_wdata <= cap_q) else $error("blend above cap");

  a_reject_no_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o[0]) |-> pixel_alpha_o == 8'd0)
    else $error("rejected draw carries alpha");

endmodule
